/* hdl/srlm_pkg.sv */
// Package for the stereo RMS level meter.
// Holds widths, scaling constants and command codes; depends on nothing.
`timescale 1ns / 1ps

package srlm_pkg;

  localparam int SAMPLE_W = 24;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int SUM_W    = 64;
  localparam int COUNT_W  = 16;
  localparam int DIVISOR_W = COUNT_W + 1;
  localparam int MEAN_W   = SQ_W;
  localparam int ROOT_W   = MEAN_W / 2;
  localparam int LEVEL_W  = 9;
  localparam int SCALE_W  = 12;
  localparam int PROD_W   = ROOT_W + SCALE_W;

  localparam int FULL_SCALE_SHIFT = 23;
  localparam logic [SCALE_W-1:0] PERCENT_SCALE = SCALE_W'(3200);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = LEVEL_W'(9'h1FF);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = COUNT_W'(16'hFFFF);

  localparam int BLOCK_PAIRS_DEFAULT = 1024;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

endpackage

/* hdl/stereo_rms_level_meter.sv */
// Stereo RMS level meter, top level.
// Uses srlm_pkg, srlm_sqacc, srlm_div and srlm_sqrt.
//
// Usage: each input transaction carries cmd plus a signed 24-bit stereo pair.
// cmd = 0 squares both samples into a 64-bit energy sum and counts the pair;
// cmd = 1 zeroes sum and count. Every input transaction yields exactly one
// output transaction with the level (floor sqrt of sum / (2 * count), times
// 3200, shifted right by 23, saturated at 511), block_full and pair_dropped.
// Once the count reaches 65535, further pairs are ignored and flagged.
//
// Sequencing: an add runs through the bit-serial squarer, the one-bit-per-cycle
// divider and the square root, and the final state loads the output register.
// A dropped pair skips the squarer; a clear goes straight to the final state.
// One transaction is in work at a time: in_stall is high while the sequencer is
// busy, so no new transaction is taken until the sequencer is idle again.
//
// Reset clears the sum, the count and any pending result. If the receiver
// stalls, the finished result holds in the output register, a new input
// transaction is still accepted, and its own result waits until the register
// frees up.
`timescale 1ns / 1ps

module stereo_rms_level_meter
  import srlm_pkg::*;
#(
  parameter int BLOCK_PAIRS = BLOCK_PAIRS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LEVEL_W-1:0]         level,
  output logic                       block_full,
  output logic                       pair_dropped
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } state_t;

  state_t               state;
  logic [SUM_W-1:0]     energy_sum;
  logic [COUNT_W-1:0]   pair_count;
  logic                 zero_level;
  logic                 dropped;

  // Samples are captured at acceptance so the squarer sees stable operands.
  logic signed [SAMPLE_W-1:0] left_sample_q;
  logic signed [SAMPLE_W-1:0] right_sample_q;

  logic                 sq_start;
  logic                 sq_done;
  logic [SQ_W-1:0]      sq_sum;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_W-1:0]     mean;
  logic                 sqrt_start;
  logic                 sqrt_done;
  logic [ROOT_W-1:0]    root;

  logic                 in_take;
  logic                 out_free;
  logic [PROD_W-1:0]    product;
  logic [PROD_W-FULL_SCALE_SHIFT-1:0] scaled;
  logic [LEVEL_W-1:0]   level_calc;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // The root is below 2^24, so the scaled product fits in 36 bits.
  assign product    = PROD_W'(root) * PROD_W'(PERCENT_SCALE);
  assign scaled     = product[PROD_W-1:FULL_SCALE_SHIFT];
  assign level_calc = (scaled > (PROD_W - FULL_SCALE_SHIFT)'(LEVEL_MAX)) ? LEVEL_MAX
                                                                         : scaled[LEVEL_W-1:0];

  srlm_sqacc u_sqacc (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .left_in  (left_sample_q),
    .right_in (right_sample_q),
    .done     (sq_done),
    .sum      (sq_sum)
  );

  srlm_div #(
    .DIVIDEND_W (SUM_W),
    .DIV_W      (DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (energy_sum),
    .divisor  ({pair_count, 1'b0}),
    .done     (div_done),
    .quotient (mean)
  );

  // The mean of squared 24-bit samples stays below 2^47, so its low 48 bits
  // carry the whole value into the root unit.
  srlm_sqrt #(
    .RAD_W (MEAN_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (mean[MEAN_W-1:0]),
    .done     (sqrt_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (in_take) begin
      left_sample_q  <= left_sample;
      right_sample_q <= right_sample;
    end
  end

  // Sequencer: holds the accumulator state, the unit start pulses and the
  // output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      energy_sum <= '0;
      pair_count <= '0;
      sq_start   <= 1'b0;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      sq_start   <= 1'b0;
      div_start  <= 1'b0;
      sqrt_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (cmd == CMD_CLEAR) begin
              energy_sum <= '0;
              pair_count <= '0;
              zero_level <= 1'b1;
              dropped    <= 1'b0;
              state      <= ST_FIN;
            end else if (pair_count == COUNT_MAX) begin
              // The count is saturated: nothing changes, but the level is
              // still reported from the current sum.
              zero_level <= 1'b0;
              dropped    <= 1'b1;
              div_start  <= 1'b1;
              state      <= ST_DIV;
            end else begin
              zero_level <= 1'b0;
              dropped    <= 1'b0;
              sq_start   <= 1'b1;
              state      <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          if (sq_done) begin
            energy_sum <= energy_sum + SUM_W'(sq_sum);
            pair_count <= pair_count + COUNT_W'(1);
            div_start  <= 1'b1;
            state      <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            sqrt_start <= 1'b1;
            state      <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            level        <= zero_level ? '0 : level_calc;
            block_full   <= {1'b0, pair_count} >= (COUNT_W + 1)'(BLOCK_PAIRS);
            pair_dropped <= dropped;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted transaction always puts the sequencer to work.
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state != ST_IDLE)
    else $error("sequencer stayed idle after an input transaction");

  // A dropped pair happens only at the count limit, which reaches any block size of at most 65535 pairs.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && pair_dropped |-> block_full)
    else $error("dropped pair reported without block_full");

  // The divider is never started with a zero pair count.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> pair_count != '0)
    else $error("divider started with zero divisor");

  // The mean handed to the root unit fits its radicand width.
  a_mean_fits: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> mean[SUM_W-1:MEAN_W] == '0)
    else $error("mean exceeds root unit width");

  // Results only leave the final state toward idle.
  a_fin_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_free |=> state == ST_IDLE && out_valid)
    else $error("final state did not load the output register");

endmodule

/* hdl/srlm_sqacc.sv */
// Bit-serial sum of squares of one stereo pair: |l|^2 + |r|^2.
// Shift-and-add over the sample magnitudes; uses srlm_pkg.
`timescale 1ns / 1ps

module srlm_sqacc
  import srlm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] left_in,
  input  logic signed [SAMPLE_W-1:0] right_in,
  output logic                       done,
  output logic [SQ_W-1:0]            sum
);

  localparam int CNT_W = $clog2(SAMPLE_W);

  function automatic logic [SAMPLE_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] x);
    logic [SAMPLE_W-1:0] u;
    u = SAMPLE_W'(x);
    return x[SAMPLE_W-1] ? (~u + SAMPLE_W'(1)) : u;
  endfunction

  logic                busy;
  logic                second;
  logic [CNT_W-1:0]    cnt;
  logic [SQ_W-1:0]     multiplicand;
  logic [SAMPLE_W-1:0] multiplier;
  logic [SAMPLE_W-1:0] right_mag;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy   <= 1'b0;
      second <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      busy         <= 1'b1;
      second       <= 1'b0;
      cnt          <= '0;
      sum          <= '0;
      multiplicand <= SQ_W'(magnitude(left_in));
      multiplier   <= magnitude(left_in);
      right_mag    <= magnitude(right_in);
    end else if (busy) begin
      if (multiplier[0]) begin
        sum <= sum + multiplicand;
      end
      if (cnt == CNT_W'(SAMPLE_W - 1)) begin
        cnt <= '0;
        if (second) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          second       <= 1'b1;
          multiplicand <= SQ_W'(right_mag);
          multiplier   <= right_mag;
        end
      end else begin
        cnt          <= cnt + CNT_W'(1);
        multiplicand <= {multiplicand[SQ_W-2:0], 1'b0};
        multiplier   <= {1'b0, multiplier[SAMPLE_W-1:1]};
      end
    end
  end

endmodule

/* hdl/srlm_div.sv */
// Restoring divider, one quotient bit per cycle.
// Generic widths set by the parent; uses srlm_pkg for the default widths.
`timescale 1ns / 1ps

module srlm_div
  import srlm_pkg::*;
#(
  parameter int DIVIDEND_W = SUM_W,
  parameter int DIV_W      = DIVISOR_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIV_W-1:0]      divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   trial;
  logic             fits;

  // The partial remainder stays below the divisor, so DIV_W bits hold it.
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DIV_W'(trial - {1'b0, dsr}) : DIV_W'(trial);
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
      if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/srlm_sqrt.sv */
// Digit-by-digit floor square root, one root bit per cycle.
// Consumes two radicand bits per step; uses srlm_pkg for default widths.
`timescale 1ns / 1ps

module srlm_sqrt
  import srlm_pkg::*;
#(
  parameter int RAD_W = MEAN_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RAD_W-1:0]     radicand,
  output logic                 done,
  output logic [RAD_W/2-1:0]   root
);

  localparam int RT_W  = RAD_W / 2;
  localparam int REM_W = RT_W + 2;
  localparam int CNT_W = $clog2(RT_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] test;
  logic             fits;

  assign trial = {rem, rad[RAD_W-1 -: 2]};
  assign test  = (REM_W + 2)'({root, 2'b01});
  assign fits  = trial >= test;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= fits ? REM_W'(trial - test) : REM_W'(trial);
      root <= {root[RT_W-2:0], fits};
      rad  <= {rad[RAD_W-3:0], 2'b00};
      if (cnt == CNT_W'(RT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

endmodule

/* dv/stereo_rms_level_meter_tb.sv */
// Self-checking testbench for the stereo RMS level meter.
// Depends on srlm_pkg and stereo_rms_level_meter; predicts every reading in the bench.
`timescale 1ns / 1ps

module stereo_rms_level_meter_tb;
  import srlm_pkg::*;

  // The block is instantiated with its default block size, so the bench uses the same value.
  localparam int BLOCK_SIZE = BLOCK_PAIRS_DEFAULT;

  // Cycles that the receiver holds off in one stretch. This is long enough for the
  // block to finish one item, take the next, finish that one too and stall its input.
  localparam int HOLD_CYCLES = 2000;

  // Cycles to wait after the last reading.
  localparam int TAIL_CYCLES = 400;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One pending input transaction. When drain is set, the sender waits until every
  // reading it expects has arrived before it offers this transaction.
  typedef struct {
    logic    op;
    sample_t left;
    sample_t right;
    logic    drain;
  } stereo_item_t;

  // One expected output transaction.
  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic               full;
    logic               dropped;
  } meter_reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               cmd = CMD_ADD;
  sample_t            left_sample = '0;
  sample_t            right_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LEVEL_W-1:0] level;
  logic               block_full;
  logic               pair_dropped;

  stereo_item_t   pair_queue[$];
  meter_reading_t reading_queue[$];

  // The bench's own copy of the accumulator state.
  logic [63:0]        energy_acc;
  logic [COUNT_W-1:0] pairs_held;

  int unsigned items_accepted = 0;
  int unsigned readings_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_limit = 64'd100000;

  stereo_rms_level_meter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .level        (level),
    .block_full   (block_full),
    .pair_dropped (pair_dropped)
  );

  always #5 clk = ~clk;

  // Floor square root, found one result bit at a time from the top down.
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Applies one accepted transaction to the accumulator copy and queues the reading
  // that the block must report for it.
  task automatic predict_reading(input logic op, input sample_t l, input sample_t r);
    meter_reading_t    rd;
    logic signed [47:0] lw;
    logic signed [47:0] rw;
    logic [47:0]       lsq;
    logic [47:0]       rsq;
    logic [63:0]       mean;
    logic [63:0]       scaled;
    rd.dropped = 1'b0;
    lw = l;
    rw = r;
    if (op == CMD_CLEAR) begin
      energy_acc = '0;
      pairs_held = '0;
    end else if (pairs_held == COUNT_MAX) begin
      // The count is at its ceiling, so the pair is thrown away and flagged.
      rd.dropped = 1'b1;
    end else begin
      lsq = lw * lw;
      rsq = rw * rw;
      energy_acc = energy_acc + {16'b0, lsq} + {16'b0, rsq};
      pairs_held = pairs_held + 1'b1;
    end
    if (pairs_held == '0) begin
      rd.level = '0;
    end else begin
      // Mean square per channel, its root, then scaling so that full scale reads 3200.
      mean = energy_acc / {47'b0, pairs_held, 1'b0};
      scaled = (floor_root(mean) * PERCENT_SCALE) >> FULL_SCALE_SHIFT;
      rd.level = (scaled > LEVEL_MAX) ? LEVEL_MAX : scaled[LEVEL_W-1:0];
    end
    rd.full = (pairs_held >= BLOCK_SIZE);
    reading_queue.push_back(rd);
  endtask

  task automatic queue_pair(input logic op, input sample_t l, input sample_t r,
                            input logic drain);
    stereo_item_t it;
    it.op = op;
    it.left = l;
    it.right = r;
    it.drain = drain;
    pair_queue.push_back(it);
  endtask

  // Random sample whose magnitude class is random too, so that the level covers the
  // whole range instead of sitting mostly at saturation.
  function automatic sample_t rand_sample();
    sample_t s;
    s = sample_t'($urandom);
    case ($urandom_range(0, 3))
      0: s = s >>> $urandom_range(1, 8);
      1: s = s >>> $urandom_range(9, 16);
      2: s = s >>> $urandom_range(17, 23);
      default: ;
    endcase
    return s;
  endfunction

  // Sender. Every accepted transaction is predicted with the payload that was on the
  // ports at that edge. After an acceptance the sender draws a random gap, except in
  // calm windows where it sends back to back. A payload stays put while the block
  // stalls it, and in_valid is assigned once per edge.
  always @(posedge clk) begin
    logic         nxt_valid;
    stereo_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
      energy_acc = '0;
      pairs_held = '0;
      send_gap = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        predict_reading(cmd, left_sample, right_sample);
        items_accepted++;
        nxt_valid = 1'b0;
        send_gap = ((items_accepted % 512) < 96) ? 0 : $urandom_range(0, 3);
      end
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pair_queue.size() != 0 &&
                     (!pair_queue[0].drain || reading_queue.size() == 0)) begin
          it = pair_queue.pop_front();
          cmd <= it.op;
          left_sample <= it.left;
          right_sample <= it.right;
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver and checker. Each reading is compared with the oldest expectation.
  // After each accepted reading the receiver draws a random stall that runs while
  // the next reading is on offer. Twice it holds off for a long stretch that is
  // counted every cycle, whether a reading is waiting or not.
  always @(posedge clk) begin
    meter_reading_t exp_rd;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (hold_left != 0) begin
        hold_left--;
      end
      if (out_valid && !out_stall) begin
        if (reading_queue.size() == 0) begin
          $display("%0t: reading with no transaction pending: level %0d full %0b dropped %0b",
                   $time, level, block_full, pair_dropped);
          mismatch_count++;
        end else begin
          exp_rd = reading_queue.pop_front();
          if (level !== exp_rd.level) begin
            $display("%0t: level expected %0d, actual %0d", $time, exp_rd.level, level);
            mismatch_count++;
          end
          if (block_full !== exp_rd.full) begin
            $display("%0t: block_full expected %0b, actual %0b",
                     $time, exp_rd.full, block_full);
            mismatch_count++;
          end
          if (pair_dropped !== exp_rd.dropped) begin
            $display("%0t: pair_dropped expected %0b, actual %0b",
                     $time, exp_rd.dropped, pair_dropped);
            mismatch_count++;
          end
        end
        readings_seen++;
        recv_gap = ((readings_seen % 448) < 80) ? 0 : $urandom_range(0, 3);
        if (readings_seen == 60 || readings_seen == 900) begin
          hold_left = HOLD_CYCLES;
        end
      end else if (out_valid && recv_gap != 0) begin
        recv_gap--;
      end
      out_stall <= (recv_gap != 0) || (hold_left != 0);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned seg_len;

    // Directed transactions: sample extremes, sign mixes, bit patterns and the
    // clear command, which also ignores whatever samples it carries.
    queue_pair(CMD_CLEAR, 24'sh000000, 24'sh000000, 1'b0);
    queue_pair(CMD_ADD, 24'sh000000, 24'sh000000, 1'b0);    // silence gives level zero
    queue_pair(CMD_ADD, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    queue_pair(CMD_ADD, -24'sh800000, -24'sh800000, 1'b0);  // saturates the level
    queue_pair(CMD_CLEAR, 24'sh7FFFFF, -24'sh800000, 1'b0);
    queue_pair(CMD_ADD, -24'sh800000, 24'sh000000, 1'b0);
    queue_pair(CMD_ADD, 24'sh000000, 24'sh7FFFFF, 1'b0);
    queue_pair(CMD_CLEAR, 24'shFFFFFF, 24'shFFFFFF, 1'b0);
    queue_pair(CMD_ADD, 24'sh000001, -24'sh000001, 1'b0);
    queue_pair(CMD_ADD, -24'sh000001, 24'sh000001, 1'b0);
    queue_pair(CMD_ADD, 24'sh555555, 24'shAAAAAA, 1'b0);
    queue_pair(CMD_ADD, 24'shAAAAAA, 24'sh555555, 1'b0);
    queue_pair(CMD_CLEAR, 24'sh123456, 24'sh654321, 1'b0);
    queue_pair(CMD_ADD, 24'sh000A00, -24'sh000A00, 1'b0);   // level still rounds down to zero
    queue_pair(CMD_ADD, 24'sh0A0000, 24'sh0A0000, 1'b0);
    queue_pair(CMD_ADD, -24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    queue_pair(CMD_CLEAR, 24'sh000000, 24'sh000000, 1'b0);
    queue_pair(CMD_CLEAR, 24'sh000000, 24'sh000000, 1'b0);  // clear when already empty
    queue_pair(CMD_ADD, 24'sh000001, 24'sh000000, 1'b0);
    queue_pair(CMD_ADD, 24'sh100000, -24'sh100000, 1'b0);

    // Random part. It starts after a pause in which every reading drains, then one
    // long run that crosses the block size, then short runs of random length that
    // mostly start with a clear and carry a few stray clears as noise.
    queue_pair(CMD_CLEAR, rand_sample(), rand_sample(), 1'b1);
    for (int i = 0; i < BLOCK_SIZE + 16; i++) begin
      queue_pair(CMD_ADD, rand_sample(), rand_sample(), 1'b0);
    end
    random_items = BLOCK_SIZE + 17;
    while (random_items < 1600) begin
      if ($urandom_range(0, 3) != 0) begin
        queue_pair(CMD_CLEAR, rand_sample(), rand_sample(), 1'b0);
        random_items++;
      end
      seg_len = $urandom_range(1, 40);
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          queue_pair(CMD_CLEAR, rand_sample(), rand_sample(), 1'b0);
        end else begin
          queue_pair(CMD_ADD, rand_sample(), rand_sample(), 1'b0);
        end
      end
      random_items += seg_len;
    end

    // After a second pause, clear and confirm the block counts again from empty.
    queue_pair(CMD_CLEAR, 24'sh000000, 24'sh000000, 1'b1);
    queue_pair(CMD_ADD, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    queue_pair(CMD_ADD, -24'sh800000, -24'sh800000, 1'b0);
    queue_pair(CMD_CLEAR, rand_sample(), rand_sample(), 1'b0);
    for (int i = 0; i < 3; i++) begin
      queue_pair(CMD_ADD, rand_sample(), rand_sample(), 1'b0);
    end

    // Every transaction at its slowest: its work, the longest gap on both sides, plus
    // the two long hold-offs, then taken several times over.
    cycle_limit = longint'(pair_queue.size()) * 600 + 4 * HOLD_CYCLES + 100000;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pair_queue.size() != 0 || in_valid || reading_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
